// File: hw/rtl/srt_pkg.sv
// Package for the sorted record table: sizes, status codes, transaction types
// and text helper functions. No dependencies.
package srt_pkg;

    localparam int DEPTH      = 1024;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = IDX_W + 1;
    localparam int TEXT_BYTES = 40;
    localparam int TEXT_W     = 320;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_LOOKUP = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DELETED   = 3'd1;
    localparam logic [2:0] ST_FOUND     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] key_word0;
        logic [63:0] key_word1;
        logic [63:0] key_word2;
        logic [63:0] key_word3;
        logic [63:0] key_word4;
        logic [63:0] payload_word0;
        logic [63:0] payload_word1;
        logic [63:0] payload_word2;
        logic [63:0] payload_word3;
        logic [63:0] payload_word4;
        logic [15:0] year_in;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [10:0] position;
        logic        part;
        logic [63:0] text_word0;
        logic [63:0] text_word1;
        logic [63:0] text_word2;
        logic [63:0] text_word3;
        logic [63:0] text_word4;
        logic [15:0] year_out;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [TEXT_W-1:0] key;
        logic [TEXT_W-1:0] payload;
        logic [15:0]       year;
    } t_entry;

    // Zero every byte from the first NUL (or past TEXT_BYTES) onward
    function automatic logic [TEXT_W-1:0] normalize(input logic [TEXT_W-1:0] src);
        logic [TEXT_W-1:0] dst;
        logic              ended;
        logic [7:0]        c;
        dst   = '0;
        ended = 1'b0;
        for (int b = 0; b < TEXT_W / 8; b++) begin
            c = src[TEXT_W-1-8*b -: 8];
            if (b >= TEXT_BYTES || c == 8'd0) begin
                ended = 1'b1;
            end
            if (!ended) begin
                dst[TEXT_W-1-8*b -: 8] = c;
            end
        end
        return dst;
    endfunction

    // Fold A-Z to lower case in every byte
    function automatic logic [TEXT_W-1:0] fold(input logic [TEXT_W-1:0] src);
        logic [TEXT_W-1:0] dst;
        logic [7:0]        c;
        for (int b = 0; b < TEXT_W / 8; b++) begin
            c = src[8*b +: 8];
            if (c >= 8'h41 && c <= 8'h5a) begin
                c = c + 8'h20;
            end
            dst[8*b +: 8] = c;
        end
        return dst;
    endfunction

endpackage

// File: hw/rtl/sorted_record_table.sv
// Sorted record table top level: binary search sequencer over a row memory,
// shift engine for insert and delete. Depends on srt_pkg.
// Operation: binary search for the lower bound, then insert shifts
// (count - position) rows down at one row a cycle and writes the new record, delete
// shifts (count - position - 1) rows up; a lookup hit gives two results.
// Throughput: one transaction at a time, set by the single memory read port
// and the shared key comparator.
// Reset: synchronous active-low; clears entry count and control, memory kept.
module sorted_record_table (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  srt_pkg::t_in  i_in_data,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output srt_pkg::t_out o_out_data,
    input  logic          i_out_stall
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PROBE = 6'b000010,
        S_CMP   = 6'b000100,
        S_INS   = 6'b001000,
        S_DEL   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    srt_pkg::t_entry r_mem [srt_pkg::DEPTH];
    srt_pkg::t_entry r_rd;

    logic [srt_pkg::CNT_W-1:0]  r_count, n_count;
    logic [srt_pkg::CNT_W-1:0]  r_lo, n_lo, r_hi, n_hi;
    logic [srt_pkg::CNT_W-1:0]  r_idx, n_idx;
    logic [srt_pkg::IDX_W-1:0]  r_waddr, n_waddr;
    logic                       r_wpend, n_wpend;
    logic                       r_final, n_final;
    logic [1:0]                 r_kind, n_kind;
    logic [srt_pkg::TEXT_W-1:0] r_key, n_key, r_pay, n_pay;
    logic [15:0]                r_year, n_year;
    srt_pkg::t_out              r_out, n_out;

    logic                       rd_en, wr_en;
    logic [srt_pkg::IDX_W-1:0]  rd_addr, wr_addr;
    srt_pkg::t_entry            wr_data;
    logic [srt_pkg::CNT_W-1:0]  mid;
    logic [srt_pkg::TEXT_W-1:0] fold_rd, fold_key;
    logic                       in_acc, out_acc;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_acc     = o_out_valid && !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_data  = r_out;

    assign mid      = r_lo + ((r_hi - r_lo) >> 1);
    assign fold_rd  = srt_pkg::fold(r_rd.key);
    assign fold_key = srt_pkg::fold(r_key);

    // Row memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // Build a result with no text
    function automatic srt_pkg::t_out plain(input logic [2:0] st,
                                            input logic [10:0] pos);
        srt_pkg::t_out o;
        o          = '0;
        o.status   = st;
        o.position = pos;
        o.last     = 1'b1;
        return o;
    endfunction

    // Sequencer
    always_comb begin
        logic decide;
        logic hit;
        n_state = r_state;
        n_count = r_count;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_idx   = r_idx;
        n_waddr = r_waddr;
        n_wpend = r_wpend;
        n_final = r_final;
        n_kind  = r_kind;
        n_key   = r_key;
        n_pay   = r_pay;
        n_year  = r_year;
        n_out   = r_out;
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = r_waddr;
        wr_data = r_rd;
        decide  = 1'b0;
        hit     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                // Take a transaction and normalize its texts
                if (in_acc && i_in_data.kind != srt_pkg::KIND_NONE) begin
                    n_kind  = i_in_data.kind;
                    n_key   = srt_pkg::normalize({i_in_data.key_word0,
                        i_in_data.key_word1, i_in_data.key_word2,
                        i_in_data.key_word3, i_in_data.key_word4});
                    n_pay   = srt_pkg::normalize({i_in_data.payload_word0,
                        i_in_data.payload_word1, i_in_data.payload_word2,
                        i_in_data.payload_word3, i_in_data.payload_word4});
                    n_year  = i_in_data.year_in;
                    n_lo    = '0;
                    n_hi    = r_count;
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                // Issue a probe read, or the final read at the lower bound
                if (r_lo < r_hi) begin
                    rd_en   = 1'b1;
                    rd_addr = mid[srt_pkg::IDX_W-1:0];
                    n_final = 1'b0;
                    n_state = S_CMP;
                end else if (r_lo < r_count) begin
                    rd_en   = 1'b1;
                    rd_addr = r_lo[srt_pkg::IDX_W-1:0];
                    n_final = 1'b1;
                    n_state = S_CMP;
                end else begin
                    decide = 1'b1;
                end
            end
            S_CMP: begin
                // Narrow the search range, or settle hit on the final read
                if (r_final) begin
                    decide = 1'b1;
                    hit    = (fold_rd == fold_key);
                end else begin
                    if (fold_rd < fold_key) begin
                        n_lo = mid + 1'b1;
                    end else begin
                        n_hi = mid;
                    end
                    n_state = S_PROBE;
                end
            end
            S_INS: begin
                // Move rows down one at a time, then write the new record
                wr_en = r_wpend;
                if (r_idx > r_lo) begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx[srt_pkg::IDX_W-1:0] - 1'b1;
                    n_waddr = r_idx[srt_pkg::IDX_W-1:0];
                    n_idx   = r_idx - 1'b1;
                    n_wpend = 1'b1;
                end else if (r_wpend) begin
                    n_wpend = 1'b0;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = r_lo[srt_pkg::IDX_W-1:0];
                    wr_data = '{key: r_key, payload: r_pay, year: r_year};
                    n_count = r_count + 1'b1;
                    n_out   = plain(srt_pkg::ST_INSERTED, r_lo);
                    n_state = S_OUT;
                end
            end
            S_DEL: begin
                // Move rows up one at a time over the removed entry
                wr_en = r_wpend;
                if (r_idx < r_count) begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx[srt_pkg::IDX_W-1:0];
                    n_waddr = r_idx[srt_pkg::IDX_W-1:0] - 1'b1;
                    n_idx   = r_idx + 1'b1;
                    n_wpend = 1'b1;
                end else if (r_wpend) begin
                    n_wpend = 1'b0;
                end else begin
                    n_count = r_count - 1'b1;
                    n_out   = plain(srt_pkg::ST_DELETED, r_lo);
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // Hand over the result; a lookup hit follows with the payload
                if (out_acc) begin
                    if (!r_out.last) begin
                        n_out.part       = 1'b1;
                        n_out.last       = 1'b1;
                        n_out.text_word0 = r_rd.payload[319:256];
                        n_out.text_word1 = r_rd.payload[255:192];
                        n_out.text_word2 = r_rd.payload[191:128];
                        n_out.text_word3 = r_rd.payload[127:64];
                        n_out.text_word4 = r_rd.payload[63:0];
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        // Dispatch once the lower bound and hit are known
        if (decide) begin
            n_state = S_OUT;
            n_wpend = 1'b0;
            unique case (r_kind)
                srt_pkg::KIND_INSERT: begin
                    if (r_count >= srt_pkg::CNT_W'(srt_pkg::DEPTH)) begin
                        n_out = plain(srt_pkg::ST_FULL, r_lo);
                    end else begin
                        n_idx   = r_count;
                        n_state = S_INS;
                    end
                end
                srt_pkg::KIND_DELETE: begin
                    if (!hit) begin
                        n_out = plain(srt_pkg::ST_NOT_FOUND, r_lo);
                    end else begin
                        n_idx   = r_lo + 1'b1;
                        n_state = S_DEL;
                    end
                end
                default: begin
                    if (!hit) begin
                        n_out = plain(srt_pkg::ST_NOT_FOUND, r_lo);
                    end else begin
                        n_out            = '0;
                        n_out.status     = srt_pkg::ST_FOUND;
                        n_out.position   = r_lo;
                        n_out.text_word0 = r_rd.key[319:256];
                        n_out.text_word1 = r_rd.key[255:192];
                        n_out.text_word2 = r_rd.key[191:128];
                        n_out.text_word3 = r_rd.key[127:64];
                        n_out.text_word4 = r_rd.key[63:0];
                        n_out.year_out   = r_rd.year;
                    end
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_wpend <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_wpend <= n_wpend;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_idx   <= n_idx;
        r_waddr <= n_waddr;
        r_final <= n_final;
        r_kind  <= n_kind;
        r_key   <= n_key;
        r_pay   <= n_pay;
        r_year  <= n_year;
        r_out   <= n_out;
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= srt_pkg::CNT_W'(srt_pkg::DEPTH))
        else $error("entry count above depth");

    a_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && !o_out_data.last) |=> (o_out_valid && o_out_data.part))
        else $error("lookup payload result missing");

    a_ins_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_out_data.status == srt_pkg::ST_INSERTED) |->
        (r_count != '0))
        else $error("insert left table empty");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> (r_hi <= r_count))
        else $error("search range beyond count");

endmodule

// File: test/tb_sorted_record_table.sv
// Testbench for sorted_record_table: random and directed insert, delete and lookup
// transactions checked against a behavioral sorted table. Depends on srt_pkg.
module tb_sorted_record_table;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_in_valid = 1'b0;
    srt_pkg::t_in   i_in_data = '0;
    logic           o_in_stall;
    logic           o_out_valid;
    srt_pkg::t_out  o_out_data;
    logic           i_out_stall = 1'b0;

    sorted_record_table dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_data(i_in_data), .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid), .o_out_data(o_out_data), .i_out_stall(i_out_stall)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Behavioral copy of the table
    logic [srt_pkg::TEXT_W-1:0] tbl_key [$];
    logic [srt_pkg::TEXT_W-1:0] tbl_pay [$];
    logic [15:0]                tbl_year [$];

    srt_pkg::t_in  pending_reqs [$];
    srt_pkg::t_out expected_results [$];
    int   mismatches = 0;
    int   n_sent = 0;
    int   n_checked = 0;
    int   n_full = 0;
    int   n_hits = 0;
    bit   stim_done = 1'b0;

    function automatic logic [srt_pkg::TEXT_W-1:0] clean_text(
            input logic [srt_pkg::TEXT_W-1:0] s);
        logic [srt_pkg::TEXT_W-1:0] d;
        bit                         stop;
        logic [7:0]                 c;
        d = '0;
        stop = 1'b0;
        for (int b = 0; b < srt_pkg::TEXT_W / 8; b++) begin
            c = s[srt_pkg::TEXT_W-1-8*b -: 8];
            if (b >= srt_pkg::TEXT_BYTES || c == 8'd0) stop = 1'b1;
            if (!stop) d[srt_pkg::TEXT_W-1-8*b -: 8] = c;
        end
        return d;
    endfunction

    // -1, 0, 1 after folding A-Z, unsigned bytes
    function automatic int key_order(input logic [srt_pkg::TEXT_W-1:0] a,
                                     input logic [srt_pkg::TEXT_W-1:0] b);
        logic [7:0] x, y;
        for (int i = 0; i < srt_pkg::TEXT_W / 8; i++) begin
            x = a[srt_pkg::TEXT_W-1-8*i -: 8];
            y = b[srt_pkg::TEXT_W-1-8*i -: 8];
            if (x >= 8'h41 && x <= 8'h5a) x = x + 8'h20;
            if (y >= 8'h41 && y <= 8'h5a) y = y + 8'h20;
            if (x < y) return -1;
            if (x > y) return 1;
        end
        return 0;
    endfunction

    function automatic srt_pkg::t_out make_result(input logic [2:0] st, input int pos,
                                                  input logic pt,
                                                  input logic [srt_pkg::TEXT_W-1:0] txt,
                                                  input logic [15:0] yr, input logic lst);
        srt_pkg::t_out r;
        r.status = st;
        r.position = pos[10:0];
        r.part = pt;
        {r.text_word0, r.text_word1, r.text_word2, r.text_word3, r.text_word4} = txt;
        r.year_out = yr;
        r.last = lst;
        return r;
    endfunction

    // Apply one accepted request to the table and queue its results
    task automatic predict_table_op(input srt_pkg::t_in req);
        logic [srt_pkg::TEXT_W-1:0] k;
        int lo, hi, mid;
        bit hit;
        k = clean_text({req.key_word0, req.key_word1, req.key_word2,
                        req.key_word3, req.key_word4});
        if (req.kind == srt_pkg::KIND_NONE) return;
        lo = 0;
        hi = tbl_key.size();
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (key_order(tbl_key[mid], k) < 0) lo = mid + 1;
            else hi = mid;
        end
        hit = lo < tbl_key.size() && key_order(tbl_key[lo], k) == 0;
        if (req.kind == srt_pkg::KIND_INSERT) begin
            if (tbl_key.size() >= srt_pkg::DEPTH) begin
                n_full++;
                expected_results.push_back(make_result(srt_pkg::ST_FULL, lo, 1'b0, '0, '0,
                                                       1'b1));
            end else begin
                tbl_key.insert(lo, k);
                tbl_pay.insert(lo, clean_text({req.payload_word0, req.payload_word1,
                    req.payload_word2, req.payload_word3, req.payload_word4}));
                tbl_year.insert(lo, req.year_in);
                expected_results.push_back(make_result(srt_pkg::ST_INSERTED, lo, 1'b0, '0,
                                                       '0, 1'b1));
            end
        end else if (!hit) begin
            expected_results.push_back(make_result(srt_pkg::ST_NOT_FOUND, lo, 1'b0, '0, '0,
                                                   1'b1));
        end else if (req.kind == srt_pkg::KIND_DELETE) begin
            tbl_key.delete(lo);
            tbl_pay.delete(lo);
            tbl_year.delete(lo);
            expected_results.push_back(make_result(srt_pkg::ST_DELETED, lo, 1'b0, '0, '0,
                                                   1'b1));
        end else begin
            n_hits++;
            expected_results.push_back(make_result(srt_pkg::ST_FOUND, lo, 1'b0, tbl_key[lo],
                                                   tbl_year[lo], 1'b0));
            expected_results.push_back(make_result(srt_pkg::ST_FOUND, lo, 1'b1, tbl_pay[lo],
                                                   tbl_year[lo], 1'b1));
        end
    endtask

    task automatic report_mismatch(input string what, input srt_pkg::t_out got,
                                   input srt_pkg::t_out want);
        mismatches++;
        $display("MISMATCH %s: got %h want %h", what, got, want);
    endtask

    // Keys drawn from a small alphabet so that equal and case-folded keys recur
    function automatic logic [srt_pkg::TEXT_W-1:0] pick_text(input bit wild);
        logic [srt_pkg::TEXT_W-1:0] t;
        int len;
        logic [7:0] alpha [6] = '{8'h41, 8'h61, 8'h42, 8'h62, 8'h5a, 8'h7a};
        t = '0;
        if (wild) begin
            for (int i = 0; i < srt_pkg::TEXT_W / 32; i++) t[32*i +: 32] = $urandom;
            return t;
        end
        len = $urandom_range(1, 4);
        if ($urandom_range(0, 15) == 0) len = 40;
        for (int i = 0; i < len; i++) t[srt_pkg::TEXT_W-1-8*i -: 8] = alpha[$urandom_range(0, 5)];
        if (len < 40 && $urandom_range(0, 7) == 0) t[srt_pkg::TEXT_W-1-8*len -: 8] = 8'hff;
        return t;
    endfunction

    function automatic srt_pkg::t_in make_req(input logic [1:0] kd,
                                              input logic [srt_pkg::TEXT_W-1:0] k,
                                              input logic [srt_pkg::TEXT_W-1:0] p,
                                              input logic [15:0] yr);
        srt_pkg::t_in r;
        r.kind = kd;
        {r.key_word0, r.key_word1, r.key_word2, r.key_word3, r.key_word4} = k;
        {r.payload_word0, r.payload_word1, r.payload_word2,
         r.payload_word3, r.payload_word4} = p;
        r.year_in = yr;
        return r;
    endfunction

    // Stimulus: directed cases, a random mix, then a few closing requests
    initial begin
        logic [srt_pkg::TEXT_W-1:0] ones, k;
        int roll;
        ones = '1;
        pending_reqs.push_back(make_req(srt_pkg::KIND_LOOKUP, '0, '0, '0));
        pending_reqs.push_back(make_req(srt_pkg::KIND_DELETE, ones, '0, '0));
        pending_reqs.push_back(make_req(srt_pkg::KIND_INSERT, '0, ones, 16'hffff));
        pending_reqs.push_back(make_req(srt_pkg::KIND_INSERT, ones, ones, 16'h0000));
        pending_reqs.push_back(make_req(srt_pkg::KIND_INSERT, {8'h41, 312'd0},
                                        {8'h61, 312'd0}, 16'd7));
        pending_reqs.push_back(make_req(srt_pkg::KIND_INSERT, {8'h61, 312'd0}, ones, 16'd8));
        pending_reqs.push_back(make_req(srt_pkg::KIND_LOOKUP, {8'h61, 312'd0}, '0, '0));
        pending_reqs.push_back(make_req(srt_pkg::KIND_LOOKUP, {8'h41, 8'h00, 8'h55, 296'd0},
                                        '0, '0));
        pending_reqs.push_back(make_req(srt_pkg::KIND_LOOKUP, ones, '0, '0));
        pending_reqs.push_back(make_req(srt_pkg::KIND_LOOKUP, '0, '0, '0));
        pending_reqs.push_back(make_req(srt_pkg::KIND_NONE, ones, ones, 16'hffff));
        pending_reqs.push_back(make_req(srt_pkg::KIND_DELETE, {8'h41, 312'd0}, '0, '0));
        pending_reqs.push_back(make_req(srt_pkg::KIND_LOOKUP, {8'h41, 312'd0}, '0, '0));
        pending_reqs.push_back(make_req(srt_pkg::KIND_DELETE, {8'h5b, 312'd0}, '0, '0));
        pending_reqs.push_back(make_req(srt_pkg::KIND_DELETE, ones, '0, '0));
        for (int n = 0; n < 517; n++) begin
            roll = $urandom_range(0, 99);
            k = pick_text(roll < 5);
            if (roll < 45)
                pending_reqs.push_back(make_req(srt_pkg::KIND_INSERT, k,
                                                pick_text($urandom_range(0, 1) == 1),
                                                16'($urandom)));
            else if (roll < 65)
                pending_reqs.push_back(make_req(srt_pkg::KIND_DELETE, k, pick_text(1'b1),
                                                16'($urandom)));
            else if (roll < 97)
                pending_reqs.push_back(make_req(srt_pkg::KIND_LOOKUP, k, pick_text(1'b1),
                                                16'($urandom)));
            else
                pending_reqs.push_back(make_req(srt_pkg::KIND_NONE, k, pick_text(1'b1),
                                                16'($urandom)));
        end
        for (int n = 0; n < 6; n++)
            pending_reqs.push_back(make_req(srt_pkg::KIND_LOOKUP, {8'h7e, 8'(n), 304'd0},
                                            '0, '0));
        pending_reqs.push_back(make_req(srt_pkg::KIND_DELETE, {8'h7e, 8'd3, 304'd0}, '0, '0));
        pending_reqs.push_back(make_req(srt_pkg::KIND_INSERT, '0, '0, 16'd1));
    end

    // Driver: hold each transaction until accepted, random gap between them
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                predict_table_op(i_in_data);
                n_sent++;
                void'(pending_reqs.pop_front());
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            end
            if (i_in_valid && o_in_stall) begin
                // hold
            end else if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                i_in_valid <= 1'b1;
                i_in_data <= pending_reqs[0];
            end else begin
                i_in_valid <= 1'b0;
                stim_done = 1'b1;
            end
        end
    end

    // Monitor: compare each accepted result with the oldest expectation
    int stall_left = 0;
    srt_pkg::t_out want;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                n_checked++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected", o_out_data, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_out_data !== want) report_mismatch("field", o_out_data, want);
                end
                stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Reset, wait for drain, report
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done && !i_in_valid && expected_results.size() == 0);
        repeat (srt_pkg::DEPTH + 50) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            mismatches++;
            $display("MISMATCH %0d results never arrived", expected_results.size());
        end
        $display("Covered %0d requests, %0d results, %0d lookup hits, %0d full-table inserts",
                 n_sent, n_checked, n_hits, n_full);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #60000000;
        $display("Mismatches found");
        $finish;
    end
endmodule

// File: sim.f
hw/rtl/srt_pkg.sv
hw/rtl/sorted_record_table.sv
test/tb_sorted_record_table.sv
